>>> design/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge outside reset.
`define RRTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rrts assertion failed");
// Checked on every rising edge, reset included.
`define RRTS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rrts assertion failed");
`else
`define RRTS_ASSERT(lbl, prop)
`define RRTS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> design/rrts_pkg.sv
// Types, codes and defaults of the round-robin thread scheduler.
`default_nettype none
package rrts_pkg;
  localparam int MAX_THREADS_DEF = 16;
  localparam int PRIO_LEVELS_DEF = 4;
  localparam int QW = 31;
  localparam int CFG_AW = 5;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_SPAWN   = 3'd1;
  localparam logic [2:0] OP_TERM    = 3'd2;
  localparam logic [2:0] OP_BLOCK   = 3'd3;
  localparam logic [2:0] OP_RESUME  = 3'd4;
  localparam logic [2:0] OP_SETPRIO = 3'd5;
  localparam logic [2:0] OP_QUERY   = 3'd6;

  localparam logic [1:0] SS_FREE  = 2'd0;
  localparam logic [1:0] SS_READY = 2'd1;
  localparam logic [1:0] SS_RUN   = 2'd2;
  localparam logic [1:0] SS_BLK   = 2'd3;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_ERR  = 2'd1;
  localparam logic [1:0] STS_EXIT = 2'd2;

  localparam logic [2:0] REG_PRIO_COUNT = 3'd0;
  localparam logic [2:0] REG_Q0 = 3'd1;
  localparam logic [2:0] REG_Q1 = 3'd2;
  localparam logic [2:0] REG_Q2 = 3'd3;
  localparam logic [2:0] REG_Q3 = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  thread_id;
    logic [1:0]  priority_req;
    logic [31:0] entry_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  spawned_id;
    logic [3:0]  running_id;
    logic [31:0] total_quantums;
    logic [31:0] thread_quantums;
    logic        switched;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [1:0]  prio;
    logic [31:0] quantums;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);
endpackage
`default_nettype wire

>>> design/rrts_ram.sv
// Generic RAM with one write port and one registered read port.
`default_nettype none
module rrts_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> design/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler with per-priority quanta.
//
//   channel  direction  handshake           payload
//   in_      into       in_valid/in_stall   rrts_pkg::in_item_t
//   out_     out of     out_valid/out_stall rrts_pkg::out_item_t
//   cfg      into       psel/penable/pready paddr, pwdata, prdata
//
// One item at a time. A quantum switch follows a tick that ends the quantum or a
// terminate or block of the running thread, a spawn scans the slot table RAM for
// the lowest free slot, and a removal from the ready queue is a compaction walk
// through the queue RAM. Slot entries carry valid bits, so reset and main thread
// exit take effect at once with no clearing pass. The block takes the next item
// while a finished result waits; a second result waits until out_stall drops.
`default_nettype none
module round_robin_thread_scheduler #(
  parameter int MAX_THREADS     = rrts_pkg::MAX_THREADS_DEF,
  parameter int PRIORITY_LEVELS = rrts_pkg::PRIO_LEVELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire rrts_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output rrts_pkg::out_item_t              out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rrts_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
`include "assert_macros.svh"

  localparam int ID_W = $clog2(MAX_THREADS);
  localparam int CW   = $clog2(MAX_THREADS + 1);
  localparam int QW   = rrts_pkg::QW;

  typedef enum logic [3:0] {
    S_IDLE, S_IDCHK, S_SNRD, S_SNCUR, S_SNNXRD, S_SNNX, S_SCAN, S_RM, S_DONE
  } fsm_t;

  fsm_t                  state_r, state_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic [1:0]            pr_r, pr_nxt;
  logic                  requeue_r, requeue_nxt;
  logic [ID_W-1:0]       cur_r, cur_nxt, before_r, before_nxt;
  logic [CW-1:0]         live_r, live_nxt, len_r, len_nxt;
  logic [ID_W-1:0]       head_r, head_nxt, tail_r, tail_nxt;
  logic [31:0]           quanta_r, quanta_nxt;
  logic [QW-1:0]         ticks_r, ticks_nxt;
  logic [MAX_THREADS-1:0] tv_r, tv_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [ID_W-1:0]       spawned_r, spawned_nxt;
  logic [31:0]           tq_r, tq_nxt;
  logic [CW-1:0]         scan_r, scan_nxt;
  logic                  pend_r, pend_nxt;
  logic [ID_W-1:0]       rm_rptr_r, rm_rptr_nxt, rm_wptr_r, rm_wptr_nxt;
  logic [CW-1:0]         rm_cnt_r, rm_cnt_nxt, rm_keep_r, rm_keep_nxt;
  logic [ID_W-1:0]       tbl_addr_r, tbl_addr_nxt;
  logic                  tbl_vld_r, tbl_vld_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rrts_pkg::out_item_t   out_data_r, out_data_nxt;
  logic [2:0]            pcnt_r, pcnt_nxt;
  logic [QW-1:0]         qreg_r [4];
  logic [QW-1:0]         qreg_nxt [4];

  logic                  tbl_re, tbl_we, fifo_re, fifo_we;
  logic [ID_W-1:0]       tbl_raddr, tbl_waddr, fifo_raddr, fifo_waddr, fifo_wdata, fifo_q;
  logic [rrts_pkg::SLOT_W-1:0] tbl_wdata, tbl_q;
  rrts_pkg::slot_t       tbl_rd, wb;
  logic                  cfg_wr;

  function automatic logic [ID_W-1:0] ptr_inc(input logic [ID_W-1:0] p);
    return (32'(p) == MAX_THREADS - 1) ? '0 : ID_W'(p + 1'b1);
  endfunction

  function automatic logic [QW-1:0] q_eff(input logic [QW-1:0] q);
    return (q == '0) ? QW'(1) : q;
  endfunction

  function automatic rrts_pkg::slot_t slot_dflt(input logic [ID_W-1:0] a);
    rrts_pkg::slot_t s;
    s.st = (a == '0) ? rrts_pkg::SS_RUN : rrts_pkg::SS_FREE;
    s.prio = 2'd0;
    s.quantums = 32'd0;
    return s;
  endfunction

  function automatic logic prio_ok(input logic [1:0] p, input logic [2:0] cnt);
    return ({1'b0, p} < cnt) && (32'(p) < PRIORITY_LEVELS);
  endfunction

  rrts_ram #(.W(rrts_pkg::SLOT_W), .D(MAX_THREADS)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_q)
  );

  rrts_ram #(.W(ID_W), .D(MAX_THREADS)) u_fifo (
    .clk(clk), .we(fifo_we), .waddr(fifo_waddr), .wdata(fifo_wdata),
    .re(fifo_re), .raddr(fifo_raddr), .rdata(fifo_q)
  );

  // Entries never written since reset read as their reset value.
  assign tbl_rd = tbl_vld_r ? rrts_pkg::slot_t'(tbl_q) : slot_dflt(tbl_addr_r);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  always_comb begin
    case (paddr[4:2])
      rrts_pkg::REG_PRIO_COUNT: prdata = {29'd0, pcnt_r};
      rrts_pkg::REG_Q0:         prdata = {1'b0, qreg_r[0]};
      rrts_pkg::REG_Q1:         prdata = {1'b0, qreg_r[1]};
      rrts_pkg::REG_Q2:         prdata = {1'b0, qreg_r[2]};
      rrts_pkg::REG_Q3:         prdata = {1'b0, qreg_r[3]};
      default:                  prdata = 32'd0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;     op_nxt = op_r;           id_nxt = id_r;
    pr_nxt = pr_r;           requeue_nxt = requeue_r; cur_nxt = cur_r;
    before_nxt = before_r;   live_nxt = live_r;       len_nxt = len_r;
    head_nxt = head_r;       tail_nxt = tail_r;       quanta_nxt = quanta_r;
    ticks_nxt = ticks_r;     tv_nxt = tv_r;           status_nxt = status_r;
    spawned_nxt = spawned_r; tq_nxt = tq_r;           scan_nxt = scan_r;
    pend_nxt = pend_r;       rm_rptr_nxt = rm_rptr_r; rm_wptr_nxt = rm_wptr_r;
    rm_cnt_nxt = rm_cnt_r;   rm_keep_nxt = rm_keep_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    pcnt_nxt = pcnt_r;
    for (int k = 0; k < 4; k++) begin
      qreg_nxt[k] = qreg_r[k];
    end
    tbl_re = 1'b0;   tbl_raddr = '0;  tbl_we = 1'b0;  tbl_waddr = '0;
    tbl_wdata = '0;  fifo_re = 1'b0;  fifo_raddr = '0;
    fifo_we = 1'b0;  fifo_waddr = '0; fifo_wdata = '0;
    wb = tbl_rd;

    if (cfg_wr) begin
      case (paddr[4:2])
        rrts_pkg::REG_PRIO_COUNT: pcnt_nxt = pwdata[2:0];
        rrts_pkg::REG_Q0:         qreg_nxt[0] = pwdata[QW-1:0];
        rrts_pkg::REG_Q1:         qreg_nxt[1] = pwdata[QW-1:0];
        rrts_pkg::REG_Q2:         qreg_nxt[2] = pwdata[QW-1:0];
        rrts_pkg::REG_Q3:         qreg_nxt[3] = pwdata[QW-1:0];
        default:                  pcnt_nxt = pcnt_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_data.opcode;
          id_nxt = ID_W'(in_data.thread_id);
          pr_nxt = in_data.priority_req;
          status_nxt = rrts_pkg::STS_OK;
          spawned_nxt = '0;
          tq_nxt = 32'd0;
          before_nxt = cur_r;
          state_nxt = S_DONE;
          case (in_data.opcode)
            rrts_pkg::OP_TICK: begin
              if (ticks_r <= QW'(1)) begin
                requeue_nxt = 1'b1;
                state_nxt = S_SNRD;
              end else begin
                ticks_nxt = ticks_r - 1'b1;
              end
            end
            rrts_pkg::OP_SPAWN: begin
              if (live_r >= CW'(MAX_THREADS) || !prio_ok(in_data.priority_req, pcnt_r)
                  || in_data.entry_address == 32'd0) begin
                status_nxt = rrts_pkg::STS_ERR;
              end else begin
                scan_nxt = '0;
                pend_nxt = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            rrts_pkg::OP_TERM, rrts_pkg::OP_BLOCK, rrts_pkg::OP_RESUME,
            rrts_pkg::OP_SETPRIO, rrts_pkg::OP_QUERY: begin
              if (32'(in_data.thread_id) >= MAX_THREADS) begin
                status_nxt = rrts_pkg::STS_ERR;
              end else begin
                tbl_re = 1'b1;
                tbl_raddr = ID_W'(in_data.thread_id);
                requeue_nxt = 1'b0;
                state_nxt = S_IDCHK;
              end
            end
            default: status_nxt = rrts_pkg::STS_ERR;
          endcase
        end
      end

      S_IDCHK: begin
        state_nxt = S_DONE;
        // Shared setup of the queue compaction walk.
        rm_rptr_nxt = head_r;
        rm_wptr_nxt = head_r;
        rm_cnt_nxt = len_r;
        rm_keep_nxt = '0;
        pend_nxt = 1'b0;
        if (tbl_rd.st == rrts_pkg::SS_FREE) begin
          status_nxt = rrts_pkg::STS_ERR;
        end else begin
          case (op_r)
            rrts_pkg::OP_TERM: begin
              if (id_r == '0) begin
                // Main thread exit: back to the reset state, registers kept.
                tv_nxt = '0;
                cur_nxt = '0;
                live_nxt = CW'(1);
                len_nxt = '0;
                head_nxt = '0;
                tail_nxt = '0;
                quanta_nxt = 32'd0;
                ticks_nxt = q_eff(qreg_r[0]);
                status_nxt = rrts_pkg::STS_EXIT;
              end else if (id_r == cur_r) begin
                state_nxt = S_SNRD;
              end else begin
                tbl_we = 1'b1;
                tbl_waddr = id_r;
                wb = '0;
                tbl_wdata = wb;
                live_nxt = live_r - 1'b1;
                state_nxt = S_RM;
              end
            end
            rrts_pkg::OP_BLOCK: begin
              if (id_r == '0) begin
                status_nxt = rrts_pkg::STS_ERR;
              end else if (tbl_rd.st == rrts_pkg::SS_READY) begin
                tbl_we = 1'b1;
                tbl_waddr = id_r;
                wb.st = rrts_pkg::SS_BLK;
                tbl_wdata = wb;
                state_nxt = S_RM;
              end else if (tbl_rd.st == rrts_pkg::SS_RUN) begin
                state_nxt = S_SNRD;
              end
            end
            rrts_pkg::OP_RESUME: begin
              if (tbl_rd.st == rrts_pkg::SS_BLK) begin
                tbl_we = 1'b1;
                tbl_waddr = id_r;
                wb.st = rrts_pkg::SS_READY;
                tbl_wdata = wb;
                fifo_we = 1'b1;
                fifo_waddr = tail_r;
                fifo_wdata = id_r;
                tail_nxt = ptr_inc(tail_r);
                len_nxt = len_r + 1'b1;
              end
            end
            rrts_pkg::OP_SETPRIO: begin
              if (!prio_ok(pr_r, pcnt_r)) begin
                status_nxt = rrts_pkg::STS_ERR;
              end else begin
                tbl_we = 1'b1;
                tbl_waddr = id_r;
                wb.prio = pr_r;
                tbl_wdata = wb;
              end
            end
            rrts_pkg::OP_QUERY: begin
              tq_nxt = tbl_rd.quantums + 32'(id_r == cur_r);
            end
            default: status_nxt = rrts_pkg::STS_ERR;
          endcase
        end
      end

      S_SNRD: begin
        tbl_re = 1'b1;
        tbl_raddr = cur_r;
        fifo_re = 1'b1;
        fifo_raddr = head_r;
        state_nxt = S_SNCUR;
      end

      S_SNCUR: begin
        // Close the outgoing quantum and pick the next thread.
        quanta_nxt = quanta_r + 32'd1;
        wb.quantums = tbl_rd.quantums + 32'd1;
        tbl_we = 1'b1;
        tbl_waddr = cur_r;
        state_nxt = S_SNNXRD;
        if (requeue_r) begin
          if (len_r == '0) begin
            wb.st = rrts_pkg::SS_RUN;
            ticks_nxt = q_eff(qreg_r[tbl_rd.prio]);
            state_nxt = S_DONE;
          end else begin
            wb.st = rrts_pkg::SS_READY;
            fifo_we = 1'b1;
            fifo_waddr = tail_r;
            fifo_wdata = cur_r;
            tail_nxt = ptr_inc(tail_r);
            head_nxt = ptr_inc(head_r);
            cur_nxt = fifo_q;
          end
        end else begin
          if (op_r == rrts_pkg::OP_BLOCK) begin
            wb.st = rrts_pkg::SS_BLK;
          end else begin
            wb = '0;
            live_nxt = live_r - 1'b1;
          end
          if (len_r != '0) begin
            cur_nxt = fifo_q;
            head_nxt = ptr_inc(head_r);
            len_nxt = len_r - 1'b1;
          end else begin
            cur_nxt = '0;
          end
        end
        tbl_wdata = wb;
      end

      S_SNNXRD: begin
        tbl_re = 1'b1;
        tbl_raddr = cur_r;
        state_nxt = S_SNNX;
      end

      S_SNNX: begin
        tbl_we = 1'b1;
        tbl_waddr = cur_r;
        wb.st = rrts_pkg::SS_RUN;
        tbl_wdata = wb;
        ticks_nxt = q_eff(qreg_r[tbl_rd.prio]);
        state_nxt = S_DONE;
      end

      S_SCAN: begin
        // One slot read issued per cycle; its state is checked in the next cycle.
        if (scan_r < CW'(MAX_THREADS)) begin
          tbl_re = 1'b1;
          tbl_raddr = scan_r[ID_W-1:0];
          scan_nxt = scan_r + 1'b1;
        end
        pend_nxt = (scan_r < CW'(MAX_THREADS));
        if (pend_r && tbl_rd.st == rrts_pkg::SS_FREE) begin
          tbl_we = 1'b1;
          tbl_waddr = tbl_addr_r;
          wb.st = rrts_pkg::SS_READY;
          wb.prio = pr_r;
          wb.quantums = 32'd0;
          tbl_wdata = wb;
          fifo_we = 1'b1;
          fifo_waddr = tail_r;
          fifo_wdata = tbl_addr_r;
          tail_nxt = ptr_inc(tail_r);
          len_nxt = len_r + 1'b1;
          live_nxt = live_r + 1'b1;
          spawned_nxt = tbl_addr_r;
          state_nxt = S_DONE;
        end else if (!pend_r && scan_r >= CW'(MAX_THREADS)) begin
          status_nxt = rrts_pkg::STS_ERR;
          state_nxt = S_DONE;
        end
      end

      S_RM: begin
        // The write pointer trails the read pointer, so the ports never collide.
        if (rm_cnt_r != '0) begin
          fifo_re = 1'b1;
          fifo_raddr = rm_rptr_r;
          rm_rptr_nxt = ptr_inc(rm_rptr_r);
          rm_cnt_nxt = rm_cnt_r - 1'b1;
        end
        pend_nxt = (rm_cnt_r != '0);
        if (pend_r && fifo_q != id_r) begin
          fifo_we = 1'b1;
          fifo_waddr = rm_wptr_r;
          fifo_wdata = fifo_q;
          rm_wptr_nxt = ptr_inc(rm_wptr_r);
          rm_keep_nxt = rm_keep_r + 1'b1;
        end
        if (!pend_r && rm_cnt_r == '0) begin
          tail_nxt = rm_wptr_r;
          len_nxt = rm_keep_r;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.status = status_r;
          out_data_nxt.spawned_id = 4'(spawned_r);
          out_data_nxt.running_id = 4'(cur_r);
          out_data_nxt.total_quantums = quanta_r + 32'd1;
          out_data_nxt.thread_quantums = tq_r;
          out_data_nxt.switched = (cur_r != before_r);
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (tbl_we) begin
      tv_nxt[tbl_waddr] = 1'b1;
    end
    tbl_addr_nxt = tbl_re ? tbl_raddr : tbl_addr_r;
    tbl_vld_nxt  = tbl_re ? tv_r[tbl_raddr] : tbl_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r <= '0;
      live_r <= CW'(1);
      len_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      quanta_r <= 32'd0;
      ticks_r <= QW'(1000);
      tv_r <= '0;
      out_valid_r <= 1'b0;
      pend_r <= 1'b0;
      tbl_vld_r <= 1'b0;
      pcnt_r <= 3'd1;
      for (int k = 0; k < 4; k++) begin
        qreg_r[k] <= QW'(1000);
      end
    end else begin
      state_r <= state_nxt;
      cur_r <= cur_nxt;
      live_r <= live_nxt;
      len_r <= len_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      quanta_r <= quanta_nxt;
      ticks_r <= ticks_nxt;
      tv_r <= tv_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r <= pend_nxt;
      tbl_vld_r <= tbl_vld_nxt;
      pcnt_r <= pcnt_nxt;
      for (int k = 0; k < 4; k++) begin
        qreg_r[k] <= qreg_nxt[k];
      end
    end
    op_r <= op_nxt;
    id_r <= id_nxt;
    pr_r <= pr_nxt;
    requeue_r <= requeue_nxt;
    before_r <= before_nxt;
    status_r <= status_nxt;
    spawned_r <= spawned_nxt;
    tq_r <= tq_nxt;
    scan_r <= scan_nxt;
    rm_rptr_r <= rm_rptr_nxt;
    rm_wptr_r <= rm_wptr_nxt;
    rm_cnt_r <= rm_cnt_nxt;
    rm_keep_r <= rm_keep_nxt;
    tbl_addr_r <= tbl_addr_nxt;
    out_data_r <= out_data_nxt;
  end

  `RRTS_ASSERT(a_queue_fits, len_r <= live_r)
  `RRTS_ASSERT(a_main_live, live_r != '0 && live_r <= CW'(MAX_THREADS))
  `RRTS_ASSERT(a_result_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE))
  `RRTS_ASSERT(a_busy_stalls, (state_r != S_IDLE) |-> in_stall)
endmodule
`default_nettype wire
